// File: hw/rtl/bcdfm_pkg.sv
// shared widths, constants and register indexes of the bcd pulse frequency meter
package bcdfm_pkg;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 88;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 21;

    localparam int MAGNET_W    = 8;
    localparam int THRESH_W    = 21;
    localparam int COUNT_W     = 20;
    localparam int RAW_W       = 21;
    localparam int TIME_W      = 32;
    localparam int FREQ_W      = 32;
    localparam int RES_W       = 31;
    localparam int DIVISOR_W   = MAGNET_W + TIME_W;
    localparam int SCALE_W     = 30;
    localparam int NUM_W       = COUNT_W + SCALE_W;
    localparam int MUL_A_W     = COUNT_W;
    localparam int MUL_P_W     = MUL_A_W + TIME_W;
    localparam int STEP_W      = 6;

    localparam logic [SCALE_W-1:0]  MHZ_SCALE    = 30'd1000000000;
    localparam logic [RAW_W-1:0]    MAX_COUNT    = 21'd999999;
    localparam logic [FREQ_W-1:0]   FREQ_POS_MAX = 32'h7fff_ffff;
    localparam logic [FREQ_W-1:0]   FREQ_NEG_MAX = 32'h8000_0000;
    localparam logic [RES_W-1:0]    RES_MAX      = 31'h7fff_ffff;
    localparam logic [MAGNET_W-1:0] MAGNET_RESET = 8'd1;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAGNET_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_THRESHOLD = 2'd1;

endpackage

// File: hw/rtl/bcd_pulse_frequency_meter.sv
// top level of the bcd pulse frequency meter: sequencer, shared multiplier and divider
//
// s_tdata carries one poll sample: three packed-bcd counter bytes and a microsecond
// timestamp. each sample gives exactly one result on m_tdata: frequency and one-pulse
// resolution in millihertz, the stored count, a counter clear request and a flag for
// a zero interval. the cfg channel writes magnet_count (index 0) and clear_threshold
// (index 1) and is always ready; other indexes are dropped.
// after the input transaction the sample goes through decode, clear decision, two
// passes through a single 20x32 multiplier, then one shared restoring divider (one
// quotient bit a cycle) runs 50 steps for the frequency and 30 steps for the
// resolution before the result register is loaded and the next sample is taken.
// with magnet_count or interval zero the divider is skipped. s_tready is high only
// while idle.
// the result sits in an output register; the next sample is taken while it waits.
// a stalled receiver holds m_tdata and m_tvalid, and the block waits at the end of
// the following sample until the pending result is taken.
// reset clears previous count and time to zero, magnet_count to 1, threshold to 0.
module bcd_pulse_frequency_meter
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // bcd_low_byte, bcd_mid_byte, bcd_high_byte, time_us
    input  logic [bcdfm_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // frequency_mhz, resolution_mhz, pulse_count, clear_counter, zero_interval, zero pad
    output logic [bcdfm_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bcdfm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bcdfm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DECODE,
        ST_PREP,
        ST_MUL_DEN,
        ST_MUL_NUM,
        ST_DIV_FREQ,
        ST_DIV_RES,
        ST_DONE
    } state_t;

    state_t                                state_reg;
    logic [bcdfm_pkg::MAGNET_W-1:0]        magnet_reg;
    logic [bcdfm_pkg::THRESH_W-1:0]        thresh_reg;
    logic [bcdfm_pkg::COUNT_W-1:0]         prev_count_reg;
    logic [bcdfm_pkg::TIME_W-1:0]          prev_time_reg;
    logic [7:0]                            lo_reg;
    logic [7:0]                            mid_reg;
    logic [7:0]                            hi_reg;
    logic [bcdfm_pkg::TIME_W-1:0]          time_reg;
    logic [bcdfm_pkg::COUNT_W-1:0]         count_reg;
    logic [bcdfm_pkg::COUNT_W-1:0]         mag_reg;
    logic                                  neg_reg;
    logic [bcdfm_pkg::TIME_W-1:0]          dt_reg;
    logic                                  zero_reg;
    logic                                  clear_reg;
    logic [bcdfm_pkg::COUNT_W-1:0]         stored_reg;
    logic [bcdfm_pkg::DIVISOR_W-1:0]       divisor_reg;
    logic [bcdfm_pkg::NUM_W-1:0]           dvd_reg;
    logic [bcdfm_pkg::DIVISOR_W:0]         rem_reg;
    logic [bcdfm_pkg::NUM_W-1:0]           quot_reg;
    logic [bcdfm_pkg::RES_W-1:0]           res_reg;
    logic [bcdfm_pkg::STEP_W-1:0]          step_reg;
    logic                                  m_tvalid_reg;
    logic [bcdfm_pkg::FREQ_W-1:0]          out_freq_reg;
    logic [bcdfm_pkg::RES_W-1:0]           out_res_reg;
    logic [bcdfm_pkg::COUNT_W-1:0]         out_count_reg;
    logic                                  out_clear_reg;
    logic                                  out_zero_reg;

    logic [bcdfm_pkg::RAW_W-1:0]           raw_count;
    logic [bcdfm_pkg::COUNT_W-1:0]         count_sat;
    logic [bcdfm_pkg::RAW_W-1:0]           diff;
    logic [bcdfm_pkg::COUNT_W-1:0]         diff_mag;
    logic [bcdfm_pkg::RAW_W+1:0]           sum_ext;
    logic [bcdfm_pkg::RAW_W+1:0]           thresh_ext;
    logic                                  clear_now;
    logic [bcdfm_pkg::MUL_A_W-1:0]         mul_a;
    logic [bcdfm_pkg::TIME_W-1:0]          mul_b;
    logic [bcdfm_pkg::MUL_P_W-1:0]         product;
    logic [bcdfm_pkg::DIVISOR_W:0]         shifted;
    logic                                  div_ge;
    logic [bcdfm_pkg::DIVISOR_W:0]         rem_next;
    logic [bcdfm_pkg::NUM_W-1:0]           dvd_next;
    logic [bcdfm_pkg::FREQ_W-1:0]          freq_next;
    logic [bcdfm_pkg::RES_W-1:0]           res_next;
    logic                                  out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {3'b000, out_zero_reg, out_clear_reg, out_count_reg,
                        out_res_reg, out_freq_reg};
    assign out_free  = !m_tvalid_reg || m_tready;

    // bcd decode, nibbles above nine weighted as read
    always_comb
    begin
        raw_count = bcdfm_pkg::RAW_W'(lo_reg[3:0])
                  + bcdfm_pkg::RAW_W'(lo_reg[7:4])  * 21'd10
                  + bcdfm_pkg::RAW_W'(mid_reg[3:0]) * 21'd100
                  + bcdfm_pkg::RAW_W'(mid_reg[7:4]) * 21'd1000
                  + bcdfm_pkg::RAW_W'(hi_reg[3:0])  * 21'd10000
                  + bcdfm_pkg::RAW_W'(hi_reg[7:4])  * 21'd100000;
        if (raw_count > bcdfm_pkg::MAX_COUNT)
        begin
            count_sat = bcdfm_pkg::MAX_COUNT[bcdfm_pkg::COUNT_W-1:0];
        end
        else
        begin
            count_sat = raw_count[bcdfm_pkg::COUNT_W-1:0];
        end
        diff     = {1'b0, count_sat} - {1'b0, prev_count_reg};
        diff_mag = diff[bcdfm_pkg::RAW_W-1] ? bcdfm_pkg::COUNT_W'(-diff)
                                            : diff[bcdfm_pkg::COUNT_W-1:0];
    end

    // count plus difference against the threshold, signed
    always_comb
    begin
        sum_ext    = {2'b00, count_reg, 1'b0} - {3'b000, prev_count_reg};
        thresh_ext = {2'b00, thresh_reg};
        clear_now  = $signed(thresh_ext) < $signed(sum_ext);
    end

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_MUL_DEN:
            begin
                mul_a = bcdfm_pkg::MUL_A_W'(magnet_reg);
                mul_b = dt_reg;
            end
            default:
            begin
                mul_a = mag_reg;
                mul_b = bcdfm_pkg::TIME_W'(bcdfm_pkg::MHZ_SCALE);
            end
        endcase
        product = bcdfm_pkg::MUL_P_W'(mul_a) * bcdfm_pkg::MUL_P_W'(mul_b);
    end

    // shared restoring divider step
    always_comb
    begin
        shifted  = {rem_reg[bcdfm_pkg::DIVISOR_W-1:0], dvd_reg[bcdfm_pkg::NUM_W-1]};
        div_ge   = shifted >= {1'b0, divisor_reg};
        rem_next = div_ge ? shifted - {1'b0, divisor_reg} : shifted;
        dvd_next = {dvd_reg[bcdfm_pkg::NUM_W-2:0], div_ge};
    end

    // saturation of the results
    always_comb
    begin
        if (divisor_reg == '0)
        begin
            res_next = bcdfm_pkg::RES_MAX;
            if (mag_reg == '0)
            begin
                freq_next = '0;
            end
            else if (neg_reg)
            begin
                freq_next = bcdfm_pkg::FREQ_NEG_MAX;
            end
            else
            begin
                freq_next = bcdfm_pkg::FREQ_POS_MAX;
            end
        end
        else
        begin
            res_next = res_reg;
            if (neg_reg)
            begin
                if (quot_reg > bcdfm_pkg::NUM_W'(bcdfm_pkg::FREQ_NEG_MAX))
                begin
                    freq_next = bcdfm_pkg::FREQ_NEG_MAX;
                end
                else
                begin
                    freq_next = -quot_reg[bcdfm_pkg::FREQ_W-1:0];
                end
            end
            else if (quot_reg > bcdfm_pkg::NUM_W'(bcdfm_pkg::FREQ_POS_MAX))
            begin
                freq_next = bcdfm_pkg::FREQ_POS_MAX;
            end
            else
            begin
                freq_next = quot_reg[bcdfm_pkg::FREQ_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            magnet_reg     <= bcdfm_pkg::MAGNET_RESET;
            thresh_reg     <= '0;
            prev_count_reg <= '0;
            prev_time_reg  <= '0;
            lo_reg         <= '0;
            mid_reg        <= '0;
            hi_reg         <= '0;
            time_reg       <= '0;
            count_reg      <= '0;
            mag_reg        <= '0;
            neg_reg        <= 1'b0;
            dt_reg         <= '0;
            zero_reg       <= 1'b0;
            clear_reg      <= 1'b0;
            stored_reg     <= '0;
            divisor_reg    <= '0;
            dvd_reg        <= '0;
            rem_reg        <= '0;
            quot_reg       <= '0;
            res_reg        <= '0;
            step_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            out_freq_reg   <= '0;
            out_res_reg    <= '0;
            out_count_reg  <= '0;
            out_clear_reg  <= 1'b0;
            out_zero_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == bcdfm_pkg::CFG_MAGNET_COUNT)
                begin
                    magnet_reg <= cfg_data[bcdfm_pkg::MAGNET_W-1:0];
                end
                else if (cfg_index == bcdfm_pkg::CFG_CLEAR_THRESHOLD)
                begin
                    thresh_reg <= cfg_data[bcdfm_pkg::THRESH_W-1:0];
                end
            end

            // in the done state the valid flag is handled below
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        lo_reg    <= s_tdata[7:0];
                        mid_reg   <= s_tdata[15:8];
                        hi_reg    <= s_tdata[23:16];
                        time_reg  <= s_tdata[55:24];
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE:
                begin
                    count_reg <= count_sat;
                    mag_reg   <= diff_mag;
                    neg_reg   <= diff[bcdfm_pkg::RAW_W-1];
                    dt_reg    <= time_reg - prev_time_reg;
                    zero_reg  <= (time_reg == prev_time_reg);
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    clear_reg      <= clear_now;
                    stored_reg     <= clear_now ? '0 : count_reg;
                    prev_count_reg <= clear_now ? '0 : count_reg;
                    prev_time_reg  <= time_reg;
                    state_reg      <= ST_MUL_DEN;
                end
                ST_MUL_DEN:
                begin
                    divisor_reg <= product[bcdfm_pkg::DIVISOR_W-1:0];
                    state_reg   <= ST_MUL_NUM;
                end
                ST_MUL_NUM:
                begin
                    dvd_reg  <= product[bcdfm_pkg::NUM_W-1:0];
                    rem_reg  <= '0;
                    step_reg <= '0;
                    if (divisor_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_DIV_FREQ;
                    end
                end
                ST_DIV_FREQ:
                begin
                    if (step_reg == bcdfm_pkg::STEP_W'(bcdfm_pkg::NUM_W - 1))
                    begin
                        quot_reg  <= dvd_next;
                        dvd_reg   <= {bcdfm_pkg::MHZ_SCALE, bcdfm_pkg::COUNT_W'(0)};
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_DIV_RES;
                    end
                    else
                    begin
                        dvd_reg  <= dvd_next;
                        rem_reg  <= rem_next;
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_DIV_RES:
                begin
                    if (step_reg == bcdfm_pkg::STEP_W'(bcdfm_pkg::SCALE_W - 1))
                    begin
                        res_reg   <= bcdfm_pkg::RES_W'(dvd_next[bcdfm_pkg::SCALE_W-1:0]);
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        dvd_reg  <= dvd_next;
                        rem_reg  <= rem_next;
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_freq_reg  <= freq_next;
                        out_res_reg   <= res_next;
                        out_count_reg <= stored_reg;
                        out_clear_reg <= clear_reg;
                        out_zero_reg  <= zero_reg;
                        m_tvalid_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: bench/bcd_pulse_frequency_meter_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the bcd pulse frequency meter: directed samples, then random phases
import bcdfm_pkg::*;

typedef struct packed {
    logic [TIME_W-1:0] time_us;
    logic [7:0]        bcd_high_byte;
    logic [7:0]        bcd_mid_byte;
    logic [7:0]        bcd_low_byte;
} meter_sample_t;

typedef struct packed {
    logic [2:0]         pad;
    logic               zero_interval;
    logic               clear_counter;
    logic [COUNT_W-1:0] pulse_count;
    logic [RES_W-1:0]   resolution_mhz;
    logic [FREQ_W-1:0]  frequency_mhz;
} meter_reading_t;

class meter_scoreboard;
    logic [MAGNET_W-1:0] magnets;
    logic [THRESH_W-1:0] threshold;
    logic [COUNT_W-1:0]  last_count;
    logic [TIME_W-1:0]   last_time;
    meter_reading_t      expected_readings[$];
    int                  mismatches;

    function new();
        magnets    = MAGNET_RESET;
        threshold  = '0;
        last_count = '0;
        last_time  = '0;
        mismatches = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        if (index == CFG_MAGNET_COUNT)
            magnets = value[MAGNET_W-1:0];
        else if (index == CFG_CLEAR_THRESHOLD)
            threshold = value[THRESH_W-1:0];
    endfunction

    function meter_reading_t measure(meter_sample_t s);
        longint unsigned   decoded;
        longint unsigned   divisor;
        longint unsigned   magnitude;
        longint unsigned   quotient;
        longint            change;
        logic [TIME_W-1:0] interval;
        logic [FREQ_W-1:0] quotient_bits;
        logic              clear;
        meter_reading_t    r;
        decoded = s.bcd_low_byte[3:0] + 10 * s.bcd_low_byte[7:4]
                + 100 * s.bcd_mid_byte[3:0] + 1000 * s.bcd_mid_byte[7:4]
                + 10000 * s.bcd_high_byte[3:0] + 100000 * s.bcd_high_byte[7:4];
        if (decoded > 64'd999999)
            decoded = 64'd999999;
        interval  = s.time_us - last_time;
        change    = longint'(decoded) - longint'(last_count);
        divisor   = magnets * longint'(interval);
        magnitude = (change < 0) ? -change : change;
        r = '0;
        if (divisor == 0) begin
            if (magnitude == 0)
                r.frequency_mhz = '0;
            else
                r.frequency_mhz = (change < 0) ? FREQ_NEG_MAX : FREQ_POS_MAX;
            r.resolution_mhz = RES_MAX;
        end
        else begin
            quotient = magnitude * 64'd1000000000 / divisor;
            if (change < 0) begin
                if (quotient > 64'h8000_0000)
                    quotient = 64'h8000_0000;
                quotient_bits   = quotient[31:0];
                r.frequency_mhz = -quotient_bits;
            end
            else begin
                if (quotient > 64'h7fff_ffff)
                    quotient = 64'h7fff_ffff;
                r.frequency_mhz = quotient[31:0];
            end
            r.resolution_mhz = RES_W'(64'd1000000000 / divisor);
        end
        clear           = longint'(threshold) < longint'(decoded) + change;
        r.clear_counter = clear;
        r.pulse_count   = clear ? '0 : decoded[COUNT_W-1:0];
        r.zero_interval = (interval == 0);
        last_count      = r.pulse_count;
        last_time       = s.time_us;
        return r;
    endfunction

    function void note_sample(meter_sample_t s);
        expected_readings.push_back(measure(s));
    endfunction

    task report(string what, logic [OUT_TDATA_W-1:0] got, logic [OUT_TDATA_W-1:0] want);
        mismatches++;
        $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task check_reading(meter_reading_t got);
        meter_reading_t want;
        if (expected_readings.size() == 0) begin
            report("unexpected transaction", got, '0);
            return;
        end
        want = expected_readings.pop_front();
        if (got.frequency_mhz !== want.frequency_mhz)
            report("frequency_mhz", got.frequency_mhz, want.frequency_mhz);
        if (got.resolution_mhz !== want.resolution_mhz)
            report("resolution_mhz", got.resolution_mhz, want.resolution_mhz);
        if (got.pulse_count !== want.pulse_count)
            report("pulse_count", got.pulse_count, want.pulse_count);
        if (got.clear_counter !== want.clear_counter)
            report("clear_counter", got.clear_counter, want.clear_counter);
        if (got.zero_interval !== want.zero_interval)
            report("zero_interval", got.zero_interval, want.zero_interval);
    endtask
endclass

module bcd_pulse_frequency_meter_test;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int STALL_LIMIT       = 2000;
    localparam int DRAIN_CYCLES      = 100;
    localparam int RANDOM_PHASES     = 8;
    localparam int SAMPLES_PER_PHASE = 140;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    meter_scoreboard sb;
    bit              idling_on = 1'b1;
    int              stuck_cycles = 0;

    bcd_pulse_frequency_meter u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_reading(meter_reading_t'(m_tdata));
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic logic [23:0] to_bcd(int unsigned value);
        logic [23:0] digits;
        for (int i = 0; i < 6; i++)
        begin
            digits[4*i +: 4] = 4'(value % 10);
            value = value / 10;
        end
        return digits;
    endfunction

    function automatic meter_sample_t sample_of(logic [7:0] lo, logic [7:0] mid, logic [7:0] hi,
                                                logic [TIME_W-1:0] stamp);
        meter_sample_t s;
        s.bcd_low_byte  = lo;
        s.bcd_mid_byte  = mid;
        s.bcd_high_byte = hi;
        s.time_us       = stamp;
        return s;
    endfunction

    // mostly a plausible poll sequence, some counter restarts, some noise
    function automatic meter_sample_t next_sample();
        meter_sample_t     s;
        int unsigned       kind;
        int unsigned       count;
        logic [TIME_W-1:0] step;
        kind = $urandom_range(0, 9);
        case ($urandom_range(0, 15))
            0:       step = '0;
            1:       step = $urandom;
            2:       step = 32'hffff_ffff - $urandom_range(0, 1000);
            default: step = $urandom_range(1, 2000000);
        endcase
        s.time_us = sb.last_time + step;
        if (kind < 7)
        begin
            count = sb.last_count + ((kind == 6) ? $urandom_range(0, 200000)
                                                 : $urandom_range(0, 3000));
            if (count > 999999)
                count = 999999;
            {s.bcd_high_byte, s.bcd_mid_byte, s.bcd_low_byte} = to_bcd(count);
        end
        else if (kind == 7)
            {s.bcd_high_byte, s.bcd_mid_byte, s.bcd_low_byte} = to_bcd($urandom_range(0, 999999));
        else
        begin
            s.bcd_low_byte  = 8'($urandom);
            s.bcd_mid_byte  = 8'($urandom);
            s.bcd_high_byte = 8'($urandom);
            s.time_us       = $urandom;
        end
        return s;
    endfunction

    task automatic send_sample(meter_sample_t s);
        int gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        do @(posedge clk); while (!s_tready);
        sb.note_sample(s);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_readings.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(index, value);
        @(negedge clk);
    endtask

    task automatic load_settings(logic [MAGNET_W-1:0] magnets, logic [THRESH_W-1:0] threshold);
        drain();
        if ($urandom_range(0, 1) == 0)
            write_register(CFG_SPARE_2, CFG_DATA_W'($urandom));
        write_register(CFG_MAGNET_COUNT, {13'($urandom), magnets});
        write_register(CFG_CLEAR_THRESHOLD, threshold);
        if ($urandom_range(0, 1) == 0)
            write_register(CFG_SPARE_3, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [MAGNET_W-1:0] magnets;
        logic [THRESH_W-1:0] threshold;
        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: one magnet, threshold zero clears on any positive count
        send_sample(sample_of(8'h00, 8'h00, 8'h00, 32'h0000_0000));
        send_sample(sample_of(8'h99, 8'h99, 8'h99, 32'h0000_0000));
        send_sample(sample_of(8'hff, 8'hff, 8'hff, 32'h0000_0001));
        send_sample(sample_of(8'h0a, 8'h0f, 8'ha0, 32'hffff_ffff));
        send_sample(sample_of(8'h01, 8'h00, 8'h00, 32'h0000_0004));
        send_sample(sample_of(8'h55, 8'haa, 8'h5a, 32'h8000_0000));

        // most magnets, threshold that never clears
        load_settings(8'd255, 21'h1f_ffff);
        send_sample(sample_of(8'h99, 8'h99, 8'h99, 32'h8000_0000));
        send_sample(sample_of(8'h00, 8'h00, 8'h00, 32'h8000_0000));
        send_sample(sample_of(8'h99, 8'h99, 8'h99, 32'h8000_0001));
        send_sample(sample_of(8'h00, 8'h00, 8'h00, 32'h8000_0002));
        send_sample(sample_of(8'h01, 8'h00, 8'h00, 32'h8000_0001));
        send_sample(sample_of(8'h00, 8'h00, 8'h00, 32'h800f_4241));
        send_sample(sample_of(8'h34, 8'h12, 8'h00, 32'h801e_8481));

        // no magnets: divisor zero, also where the interval is not
        load_settings(8'd0, 21'd1000);
        send_sample(sample_of(8'h00, 8'h00, 8'h00, 32'h801e_8486));
        send_sample(sample_of(8'h00, 8'h10, 8'h00, 32'h801e_848d));
        send_sample(sample_of(8'h00, 8'h00, 8'h00, 32'h801e_848d));

        // threshold equal to count plus difference does not clear
        load_settings(8'd3, 21'd1999998);
        send_sample(sample_of(8'h99, 8'h99, 8'h99, 32'h801e_9000));

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idling_on = (phase != RANDOM_PHASES - 1);
            case (phase % 4)
                0:       magnets = 8'd1;
                1:       magnets = 8'd255;
                2:       magnets = 8'($urandom_range(2, 254));
                default: magnets = 8'($urandom_range(1, 255));
            endcase
            if (phase == 5)
                magnets = 8'd0;
            case (phase % 3)
                0:       threshold = 21'h1f_ffff;
                1:       threshold = '0;
                default: threshold = 21'($urandom_range(0, 2097151));
            endcase
            load_settings(magnets, threshold);
            repeat (SAMPLES_PER_PHASE)
                send_sample(next_sample());
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_readings.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
